>>> design/thi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_pkg
// Shared types, register map and item codes of the terrain height interpolator.
// ----------------------------------------------------------------------------
package thi_pkg;

	// largest grid side supported by the store
	localparam int MAX_SIDE_DEF = 256;

	// configuration port
	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_MAP_SIDE    = 3'd0;
	localparam logic [2:0] REG_INV_SCALE_X = 3'd1;
	localparam logic [2:0] REG_INV_SCALE_Z = 3'd2;
	localparam logic [2:0] REG_HEIGHT_SCL  = 3'd3;
	localparam logic [2:0] REG_DEFAULT_H   = 3'd4;
	localparam logic [2:0] REG_FLIP_ROWS   = 3'd5;

	// register reset values
	localparam logic [8:0]  RST_MAP_SIDE    = 9'd256;
	localparam logic [31:0] RST_INV_SCALE   = 32'h0001_0000;
	localparam logic [31:0] RST_HEIGHT_SCL  = 32'h0100_0000;
	localparam logic [31:0] RST_DEFAULT_H   = 32'h0000_0000;

	// item codes carried from front to back
	localparam logic [1:0] KIND_NOP   = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_OFF   = 2'd3;

	// request type codes
	localparam logic REQ_WRITE = 1'b0;

	typedef struct packed {
		logic [8:0]  map_side;
		logic [31:0] inv_scale_x;
		logic [31:0] inv_scale_z;
		logic [31:0] height_scale;
		logic [31:0] default_height;
		logic        flip_rows;
	} cfg_t;

endpackage

>>> design/thi_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module thi_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [thi_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output thi_pkg::cfg_t                 cfg
);
	import thi_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// register write on the access cycle of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_side       <= RST_MAP_SIDE;
			cfg_q.inv_scale_x    <= RST_INV_SCALE;
			cfg_q.inv_scale_z    <= RST_INV_SCALE;
			cfg_q.height_scale   <= RST_HEIGHT_SCL;
			cfg_q.default_height <= RST_DEFAULT_H;
			cfg_q.flip_rows      <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAP_SIDE:    cfg_q.map_side       <= pwdata[8:0];
				REG_INV_SCALE_X: cfg_q.inv_scale_x    <= pwdata;
				REG_INV_SCALE_Z: cfg_q.inv_scale_z    <= pwdata;
				REG_HEIGHT_SCL:  cfg_q.height_scale   <= pwdata;
				REG_DEFAULT_H:   cfg_q.default_height <= pwdata;
				REG_FLIP_ROWS:   cfg_q.flip_rows      <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_MAP_SIDE:    prdata = {23'd0, cfg_q.map_side};
			REG_INV_SCALE_X: prdata = cfg_q.inv_scale_x;
			REG_INV_SCALE_Z: prdata = cfg_q.inv_scale_z;
			REG_HEIGHT_SCL:  prdata = cfg_q.height_scale;
			REG_DEFAULT_H:   prdata = cfg_q.default_height;
			REG_FLIP_ROWS:   prdata = {31'd0, cfg_q.flip_rows};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

>>> design/thi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_front
// Accepts items, scales query coordinates, classifies them and forms the
// sample addresses of the cell; pushes one entry per item into the queue.
// ----------------------------------------------------------------------------
module thi_front #(
	parameter int MAX_SIDE = thi_pkg::MAX_SIDE_DEF,
	parameter int ADDR_W   = 16,
	parameter int ENT_W    = 82,
	parameter int QDEPTH   = 4,
	parameter int QCNT_W   = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  thi_pkg::cfg_t        cfg,
	input  logic                 start,
	input  logic                 req_type,
	input  logic [15:0]          sample_index,
	input  logic [15:0]          sample_value,
	input  logic signed [31:0]   query_x,
	input  logic signed [31:0]   query_z,
	input  logic [QCNT_W-1:0]    q_count,
	output logic                 busy,
	output logic                 push,
	output logic [ENT_W-1:0]     push_data
);
	import thi_pkg::*;

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam logic [8:0] SIDE_CAP = 9'((MAX_SIDE > 511) ? 511 : MAX_SIDE);

	// stage 1 registers
	logic        v_s1;
	logic        type_s1;
	logic [15:0] idx_s1;
	logic [15:0] val_s1;
	logic        neg_s1;
	logic [63:0] gx_s1;
	logic [63:0] gz_s1;

	// stage 2 registers
	logic        v_s2;
	logic [1:0]  kind_s2;
	logic [8:0]  col_s2;
	logic [17:0] r0_s2;
	logic [8:0]  side_s2;
	logic        flip_s2;
	logic [15:0] fx_s2;
	logic [15:0] fz_s2;
	logic [15:0] wdata_s2;
	logic [15:0] widx_s2;

	logic              accept;
	logic [QCNT_W:0]   occ;
	logic [8:0]        side_u;
	logic [8:0]        side1;
	logic              off;
	logic [8:0]        rowsel;
	logic [1:0]        kind_c;
	logic [ADDR_W-1:0] a0;
	logic [ADDR_W-1:0] a1;

	// credit: items in flight never exceed queue depth
	assign occ    = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(v_s1) + (QCNT_W+1)'(v_s2);
	assign busy   = occ >= (QCNT_W+1)'(QDEPTH);
	assign accept = start & ~busy;

	// stage 1: capture and scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1 <= req_type;
			idx_s1  <= sample_index;
			val_s1  <= sample_value;
			neg_s1  <= query_x[31] | query_z[31];
			gx_s1   <= {32'd0, query_x} * {32'd0, cfg.inv_scale_x};
			gz_s1   <= {32'd0, query_z} * {32'd0, cfg.inv_scale_z};
		end
	end

	// side in use, clamped
	always_comb begin
		if (cfg.map_side < 9'd2)          side_u = 9'd2;
		else if (cfg.map_side > SIDE_CAP) side_u = SIDE_CAP;
		else                              side_u = cfg.map_side;
	end
	assign side1 = side_u - 9'd1;

	// classify and pick the first row
	assign off    = neg_s1 | (gx_s1[63:32] >= {23'd0, side1}) |
	                (gz_s1[63:32] >= {23'd0, side1});
	assign rowsel = cfg.flip_rows ? (side1 - gz_s1[40:32]) : gz_s1[40:32];

	always_comb begin
		if (type_s1 == REQ_WRITE) kind_c = (32'(idx_s1) < DEPTH) ? KIND_WRITE : KIND_NOP;
		else                      kind_c = off ? KIND_OFF : KIND_QUERY;
	end

	// stage 2: row base and fractions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			kind_s2  <= kind_c;
			col_s2   <= gx_s1[40:32];
			r0_s2    <= 18'(rowsel) * 18'(side_u);
			side_s2  <= side_u;
			flip_s2  <= cfg.flip_rows;
			fx_s2    <= gx_s1[31:16];
			fz_s2    <= gz_s1[31:16];
			wdata_s2 <= val_s1;
			widx_s2  <= idx_s1;
		end
	end

	// addresses of the two rows
	always_comb begin
		if (kind_s2 == KIND_WRITE) a0 = ADDR_W'(widx_s2);
		else                       a0 = ADDR_W'(r0_s2) + ADDR_W'(col_s2);
		a1 = flip_s2 ? (a0 - ADDR_W'(side_s2)) : (a0 + ADDR_W'(side_s2));
	end

	assign push      = v_s2;
	assign push_data = {kind_s2, a0, a1, fx_s2, fz_s2, wdata_s2};

endmodule

>>> design/thi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_queue
// Short first-in first-out queue between front and back, head shown ahead.
// ----------------------------------------------------------------------------
module thi_queue #(
	parameter int WIDTH  = 82,
	parameter int DEPTH  = 4,
	parameter int CNT_W  = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  push_data,
	input  logic              pop,
	output logic [WIDTH-1:0]  head,
	output logic              empty,
	output logic [CNT_W-1:0]  count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign empty  = (count_q == '0);
	assign count  = count_q;
	assign head   = slot_q[rd_ptr_q];
	assign do_pop = pop & ~empty;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)   wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push) - CNT_W'(do_pop);
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> design/thi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_back
// Sample store and interpolation pipeline: writes samples, reads the four
// corners of a cell, builds the plane value, scales, saturates and clamps.
// ----------------------------------------------------------------------------
module thi_back #(
	parameter int MAX_SIDE = thi_pkg::MAX_SIDE_DEF,
	parameter int ADDR_W   = 16,
	parameter int ENT_W    = 82
) (
	input  logic                clk,
	input  logic                arst_n,
	input  thi_pkg::cfg_t       cfg,
	input  logic                q_empty,
	input  logic [ENT_W-1:0]    q_head,
	output logic                pop,
	output logic                result_valid,
	output logic signed [31:0]  height,
	output logic                off_map
);
	import thi_pkg::*;

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam logic signed [63:0] H_MAX = 64'(65535) << 32;

	// two copies of the store, each read at two neighbouring addresses
	logic [15:0] mem_a [DEPTH];
	logic [15:0] mem_b [DEPTH];

	logic [1:0]        e_kind;
	logic [ADDR_W-1:0] e_a0;
	logic [ADDR_W-1:0] e_a1;
	logic [15:0]       e_fx;
	logic [15:0]       e_fz;
	logic [15:0]       e_wdata;

	// stage 1
	logic        v_s1;
	logic [1:0]  kind_s1;
	logic [15:0] fx_s1;
	logic [15:0] fz_s1;
	logic [15:0] t1_s1, t2_s1, b1_s1, b2_s1;
	// stage 2
	logic                v_s2;
	logic [1:0]          kind_s2;
	logic [15:0]         fz_s2;
	logic signed [39:0]  t_s2;
	logic signed [39:0]  b_s2;
	// stage 3
	logic                v_s3;
	logic [1:0]          kind_s3;
	logic signed [63:0]  h_s3;
	// stage 4
	logic                v_s4;
	logic [1:0]          kind_s4;
	logic [63:0]         prod_s4;
	// output
	logic                result_valid_q;
	logic [31:0]         height_q;
	logic                off_map_q;

	logic signed [18:0]  c_t1, c_t2, c_b1, c_b2;
	logic signed [19:0]  dt, db;
	logic signed [16:0]  fxs;
	logic                lower;
	logic signed [63:0]  fzs;
	logic signed [63:0]  diff;
	logic signed [63:0]  hc;
	logic [39:0]         pshift;
	logic [31:0]         sat;
	logic [31:0]         res;

	assign {e_kind, e_a0, e_a1, e_fx, e_fz, e_wdata} = q_head;
	assign pop = ~q_empty;

	// store write and corner read
	always_ff @(posedge clk) begin
		if (pop && e_kind == KIND_WRITE) begin
			mem_a[e_a0] <= e_wdata;
			mem_b[e_a0] <= e_wdata;
		end
		t1_s1 <= mem_a[e_a0];
		t2_s1 <= mem_a[e_a0 + ADDR_W'(1)];
		b1_s1 <= mem_b[e_a1];
		b2_s1 <= mem_b[e_a1 + ADDR_W'(1)];
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			result_valid_q <= 1'b0;
			off_map_q      <= 1'b0;
		end else begin
			v_s1           <= pop;
			v_s2           <= v_s1;
			v_s3           <= v_s2;
			v_s4           <= v_s3;
			result_valid_q <= v_s4 && (kind_s4 == KIND_QUERY || kind_s4 == KIND_OFF);
			off_map_q      <= v_s4 && (kind_s4 == KIND_OFF);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= e_kind;
			fx_s1   <= e_fx;
			fz_s1   <= e_fz;
		end
	end

	// triangle choice and edge values
	always_comb begin
		c_t1  = $signed({3'b000, t1_s1});
		c_t2  = $signed({3'b000, t2_s1});
		c_b1  = $signed({3'b000, b1_s1});
		c_b2  = $signed({3'b000, b2_s1});
		lower = ({1'b0, fx_s1} + {1'b0, fz_s1}) <= 17'h1_0000;
		if (lower) c_b2 = c_b1 + c_t2 - c_t1;
		else       c_t1 = c_b1 + c_t2 - c_b2;
		dt  = 20'(c_t2) - 20'(c_t1);
		db  = 20'(c_b2) - 20'(c_b1);
		fxs = $signed({1'b0, fx_s1});
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			kind_s2 <= kind_s1;
			fz_s2   <= fz_s1;
			t_s2    <= (40'(c_t1) <<< 16) + 40'(fxs) * 40'(dt);
			b_s2    <= (40'(c_b1) <<< 16) + 40'(fxs) * 40'(db);
		end
	end

	// plane value between the edges
	assign fzs  = 64'($signed({1'b0, fz_s2}));
	assign diff = 64'(b_s2) - 64'(t_s2);

	always_ff @(posedge clk) begin
		if (v_s2) begin
			kind_s3 <= kind_s2;
			h_s3    <= (64'(t_s2) <<< 16) + fzs * diff;
		end
	end

	// clamp to sample range and scale
	always_comb begin
		if (h_s3 < 64'sd0)      hc = 64'sd0;
		else if (h_s3 > H_MAX)  hc = H_MAX;
		else                    hc = h_s3;
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			kind_s4 <= kind_s3;
			prod_s4 <= {32'd0, hc[47:16]} * {32'd0, cfg.height_scale};
		end
	end

	// saturate and apply the lower clamp
	always_comb begin
		pshift = prod_s4[63:24];
		sat    = (pshift > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : pshift[31:0];
		if (kind_s4 == KIND_OFF)                             res = cfg.default_height;
		else if ($signed(sat) < $signed(cfg.default_height)) res = cfg.default_height;
		else                                                 res = sat;
	end

	always_ff @(posedge clk) begin
		if (v_s4) height_q <= res;
	end

	assign result_valid = result_valid_q;
	assign height       = $signed(height_q);
	assign off_map      = off_map_q;

endmodule

>>> design/terrain_height_interpolator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_height_interpolator_unit
// Heightmap store with triangle interpolation of queried world positions.
//
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------
// request   | start / busy               | req_type, sample_index,
//           |                            | sample_value, query_x, query_z
// result    | result_valid (1 cycle)     | height, off_map
// config    | psel, penable, pwrite,     | paddr, pwdata, prdata
//           | pready                     |
//
// One item is taken per cycle while busy is low; each query transfer gives a
// result, a sample write gives no result.
// Four corner reads a cycle come from two copies of the store, each with two
// read ports. busy rises only when the front stages and the queue hold four
// items. Reset clears control and registers; the store holds nothing defined
// until samples are written. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module terrain_height_interpolator_unit #(
	parameter int MAX_SIDE = thi_pkg::MAX_SIDE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [15:0]                  sample_index,
	input  logic [15:0]                  sample_value,
	input  logic signed [31:0]           query_x,
	input  logic signed [31:0]           query_z,
	output logic                         result_valid,
	output logic signed [31:0]           height,
	output logic                         off_map,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [thi_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import thi_pkg::*;

	localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
	localparam int ENT_W  = 2 + 2 * ADDR_W + 48;
	localparam int QDEPTH = 4;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	cfg_t              cfg;
	logic              push;
	logic [ENT_W-1:0]  push_data;
	logic              pop;
	logic [ENT_W-1:0]  q_head;
	logic              q_empty;
	logic [QCNT_W-1:0] q_count;

	// configuration registers
	thi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// accept and classify
	thi_front #(
		.MAX_SIDE (MAX_SIDE),
		.ADDR_W   (ADDR_W),
		.ENT_W    (ENT_W),
		.QDEPTH   (QDEPTH),
		.QCNT_W   (QCNT_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.start        (start),
		.req_type     (req_type),
		.sample_index (sample_index),
		.sample_value (sample_value),
		.query_x      (query_x),
		.query_z      (query_z),
		.q_count      (q_count),
		.busy         (busy),
		.push         (push),
		.push_data    (push_data)
	);

	// decoupling queue
	thi_queue #(
		.WIDTH (ENT_W),
		.DEPTH (QDEPTH),
		.CNT_W (QCNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty),
		.count     (q_count)
	);

	// store and interpolation
	thi_back #(
		.MAX_SIDE (MAX_SIDE),
		.ADDR_W   (ADDR_W),
		.ENT_W    (ENT_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.pop          (pop),
		.result_valid (result_valid),
		.height       (height),
		.off_map      (off_map)
	);

endmodule

>>> design/thi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_checker
// Port-level checks of result timing, bound to the top level.
// ----------------------------------------------------------------------------
module thi_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic req_type,
	input logic result_valid,
	input logic off_map,
	input logic pready
);
	import thi_pkg::*;

	logic query_xfer;
	logic write_xfer;

	assign query_xfer = start & ~busy & (req_type != REQ_WRITE);
	assign write_xfer = start & ~busy & (req_type == REQ_WRITE);

	// every query transfer gives a result a fixed time later
	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		query_xfer |-> ##8 result_valid)
		else $error("query transfer without result");

	// a sample write gives no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		write_xfer |-> ##8 !result_valid)
		else $error("result after sample write");

	// no result without a matching query
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(query_xfer, 8))
		else $error("result without query transfer");

	// off-map flag only with a result
	a_off_map_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !off_map)
		else $error("off_map outside result");

	// configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind terrain_height_interpolator_unit thi_checker u_thi_checker (.*);
